### hw/rtl/fpq_pkg.sv
// Shared constants, types and helpers for the four-level priority queue.
// No dependencies; imported by the core and by tb/testbench.sv.
package fpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_LEVELS  = 4;

	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int ADDR_W  = LVL_W + PTR_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	localparam int ID_W        = 8;
	localparam int IN_LEVEL_W  = 2;
	localparam int OUT_LEVEL_W = 2;
	localparam int ENTRY_W     = 2 * ID_W;

	localparam int IN_FIELDS_W  = 1 + IN_LEVEL_W + 2 * ID_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + 2 * ID_W + OUT_LEVEL_W + 1;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [LVL_W-1:0] lvl_t;

	// Circular pointer step within one level's region.
	function automatic ptr_t ptr_next(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + ptr_t'(1);
		end
		return r;
	endfunction

endpackage

### hw/rtl/four_level_priority_queue_core.sv
// Strict-priority multi-level FIFO queue core with a shared entry memory.
// Depends on fpq_pkg for sizes, command codes and the pointer step.
//
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one command per
//   transfer: enqueue a (thread, process) pair at the tail of a level, or
//   dequeue the head of the most urgent non-empty level (level 0 first).
//   Output stream (m_tvalid/m_tready/m_tdata) returns exactly one result
//   per command: the served entry and its level, a not-valid result for a
//   dequeue from empty queues, or an overflow flag for a dropped enqueue.
//   Throughput: one command per cycle. Head/tail pointers and fill counts
//   update at the accepting edge, and enqueue writes the entry memory in
//   that same edge, so a dequeue in the next cycle already sees it.
//   Output: the result is registered and appears in the cycle after the
//   input transfer, taken from the registered read of the entry memory.
//   Stall: the single result register holds while m_tready is low, and
//   s_tready drops until it is taken.
//   Reset: arst_n clears pointers, counts and the result valid; all queues
//   start empty. Entry memory contents are not cleared.
module four_level_priority_queue_core
	import fpq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata: cmd[0], level[2:1], thread_id[10:3], process_id[18:11], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata: valid_res[0], out_thread[8:1], out_process[16:9],
	//          out_level[18:17], overflow[19], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata
);

	cmd_t                  cmd;
	logic [IN_LEVEL_W-1:0] level;
	logic [ID_W-1:0]       thread_id;
	logic [ID_W-1:0]       process_id;

	ptr_t head_q [NUM_LEVELS];
	ptr_t tail_q [NUM_LEVELS];
	cnt_t cnt_q  [NUM_LEVELS];

	logic [ENTRY_W-1:0] mem [MEM_DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	logic accept;
	lvl_t enq_lvl;
	logic enq_full;
	logic wr_en;
	logic rd_en;
	logic pick_hit;
	lvl_t pick_lvl;

	logic v_s1;
	logic vres_s1;
	logic ovf_s1;
	lvl_t lvl_s1;

	assign cmd        = cmd_t'(s_tdata[0]);
	assign level      = s_tdata[IN_LEVEL_W:1];
	assign thread_id  = s_tdata[IN_LEVEL_W+ID_W:IN_LEVEL_W+1];
	assign process_id = s_tdata[IN_LEVEL_W+2*ID_W:IN_LEVEL_W+ID_W+1];

	assign s_tready = !v_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Out-of-range levels fall into the least urgent queue.
	always_comb begin
		if (32'(level) >= NUM_LEVELS) begin
			enq_lvl = LVL_W'(NUM_LEVELS - 1);
		end else begin
			enq_lvl = LVL_W'(level);
		end
	end

	assign enq_full = (cnt_q[enq_lvl] == CNT_W'(QUEUE_DEPTH));

	// Most urgent non-empty level wins.
	always_comb begin
		pick_hit = 1'b0;
		pick_lvl = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				pick_hit = 1'b1;
				pick_lvl = LVL_W'(i);
			end
		end
	end

	assign wr_en = accept && (cmd == CMD_ENQ) && !enq_full;
	assign rd_en = accept && (cmd == CMD_DEQ) && pick_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (wr_en) begin
				tail_q[enq_lvl] <= ptr_next(tail_q[enq_lvl]);
				cnt_q[enq_lvl]  <= cnt_q[enq_lvl] + cnt_t'(1);
			end
			if (rd_en) begin
				head_q[pick_lvl] <= ptr_next(head_q[pick_lvl]);
				cnt_q[pick_lvl]  <= cnt_q[pick_lvl] - cnt_t'(1);
			end
		end
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{enq_lvl, tail_q[enq_lvl]}] <= {thread_id, process_id};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[{pick_lvl, head_q[pick_lvl]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vres_s1 <= rd_en;
			ovf_s1  <= (cmd == CMD_ENQ) && enq_full;
			lvl_s1  <= pick_lvl;
		end
	end

	assign m_tvalid = v_s1;

	always_comb begin
		m_tdata = '0;
		m_tdata[0] = vres_s1;
		if (vres_s1) begin
			m_tdata[ID_W:1]               = rd_q[ENTRY_W-1:ID_W];
			m_tdata[2*ID_W:ID_W+1]        = rd_q[ID_W-1:0];
			m_tdata[2*ID_W+OUT_LEVEL_W:2*ID_W+1] = OUT_LEVEL_W'(lvl_s1);
		end
		m_tdata[2*ID_W+OUT_LEVEL_W+1] = ovf_s1;
	end

`ifndef ASSERT_OFF
	a_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(ovf_s1 && vres_s1))
		else $error("result flags both overflow and valid entry");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> cnt_q[$past(enq_lvl)] == $past(cnt_q[enq_lvl]) + cnt_t'(1))
		else $error("enqueue did not bump the level's fill count");

	a_deq_served: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_DEQ && pick_hit) |=> (m_tvalid && vres_s1))
		else $error("dequeue from a non-empty queue returned no entry");

	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted command produced no result");
`endif

endmodule

### tb/testbench.sv
// Self-checking bench for four_level_priority_queue_core: queued scheduler commands,
// a strict-priority predictor and an in-order result check, with random stalls on both sides.
// Depends on fpq_pkg and the core RTL only.
module testbench;
	import fpq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_TAIL   = 120;
	localparam int RANDOM_TOTAL = 1850;
	localparam int MAX_PRINTS   = 50;

	// Fields of one command, packed as on s_tdata (lowest field last)
	typedef struct packed {
		logic [ID_W-1:0]       proc_id;
		logic [ID_W-1:0]       thread_id;
		logic [IN_LEVEL_W-1:0] level;
		cmd_t                  cmd;
	} sched_cmd_t;

	// Fields of one result, packed as on m_tdata (lowest field last)
	typedef struct packed {
		logic                   overflow;
		logic [OUT_LEVEL_W-1:0] level;
		logic [ID_W-1:0]        proc_id;
		logic [ID_W-1:0]        thread_id;
		logic                   valid_res;
	} sched_result_t;

	typedef struct {
		sched_cmd_t fields;
		bit         hold_for_drain;
	} pending_cmd_t;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	pending_cmd_t    cmd_queue[$];
	sched_result_t   expected_results[$];
	logic [ENTRY_W-1:0] level_fifo[NUM_LEVELS][$];

	sched_cmd_t in_flight_cmd;
	int         send_gap      = 0;
	int         ready_stall   = 0;
	int         accepted_cmds = 0;
	int         total_cmds    = 0;
	int         result_index  = 0;
	int         mismatch_count = 0;

	four_level_priority_queue_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void queue_cmd(cmd_t cmd, int level, int thread_id, int proc_id,
			bit hold_for_drain);
		pending_cmd_t p;
		p.fields.cmd       = cmd;
		p.fields.level     = IN_LEVEL_W'(level);
		p.fields.thread_id = ID_W'(thread_id);
		p.fields.proc_id   = ID_W'(proc_id);
		p.hold_for_drain   = hold_for_drain;
		cmd_queue.insert(cmd_queue.size(), p);
	endfunction

	// Strict-priority scheduler: append on enqueue, serve most urgent head on dequeue.
	function automatic sched_result_t serve_cmd(sched_cmd_t c);
		sched_result_t      res;
		logic [ENTRY_W-1:0] entry;
		int                 lv;
		res = '0;
		if (c.cmd == CMD_ENQ) begin
			lv = (int'(c.level) >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(c.level);
			if (level_fifo[lv].size() >= QUEUE_DEPTH) begin
				res.overflow = 1'b1;
			end else begin
				entry = {c.thread_id, c.proc_id};
				level_fifo[lv].insert(level_fifo[lv].size(), entry);
			end
		end else begin
			for (lv = 0; lv < NUM_LEVELS && !res.valid_res; lv++) begin
				if (level_fifo[lv].size() != 0) begin
					entry         = level_fifo[lv].pop_front();
					res.valid_res = 1'b1;
					res.thread_id = entry[ENTRY_W-1:ID_W];
					res.proc_id   = entry[ID_W-1:0];
					res.level     = OUT_LEVEL_W'(lv);
				end
			end
		end
		return res;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		if (mismatch_count < MAX_PRINTS) begin
			$display("[%0t] result %0d: %s got %0h, expected %0h", $realtime, result_index,
				what, got, want);
		end
		mismatch_count++;
	endtask

	task automatic check_result(sched_result_t got);
		sched_result_t want;
		if (expected_results.size() == 0) begin
			flag_mismatch("unexpected transfer, data", int'(got), 0);
		end else begin
			want = expected_results.pop_front();
			if (got.valid_res !== want.valid_res)
				flag_mismatch("valid_res", got.valid_res, want.valid_res);
			if (got.thread_id !== want.thread_id)
				flag_mismatch("out_thread", got.thread_id, want.thread_id);
			if (got.proc_id !== want.proc_id)
				flag_mismatch("out_process", got.proc_id, want.proc_id);
			if (got.level !== want.level)
				flag_mismatch("out_level", got.level, want.level);
			if (got.overflow !== want.overflow)
				flag_mismatch("overflow", got.overflow, want.overflow);
		end
		result_index++;
	endtask

	// Driver: predict on each input transfer, then present the next command.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.insert(expected_results.size(), serve_cmd(in_flight_cmd));
				accepted_cmds++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_queue.size() != 0 &&
						!(cmd_queue[0].hold_for_drain && expected_results.size() != 0)) begin
					in_flight_cmd <= cmd_queue[0].fields;
					s_tdata       <= IN_DATA_W'(cmd_queue[0].fields);
					s_tvalid      <= 1'b1;
					if (cmd_queue.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 6);
					void'(cmd_queue.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each output transfer and stall m_tready in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			ready_stall <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(sched_result_t'(m_tdata[OUT_FIELDS_W-1:0]));
			if (ready_stall > 0) begin
				ready_stall <= ready_stall - 1;
				m_tready    <= 1'b0;
			end else if (cmd_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
				ready_stall <= $urandom_range(0, 5);
				m_tready    <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int phase_len;
		int mode;
		int enq_pct;
		int focus_level;
		int lv;
		bit first_phase;

		// Extremes on every level, then served in priority order, then empty.
		queue_cmd(CMD_ENQ, 3, 8'h00, 8'h00, 1'b0);
		queue_cmd(CMD_ENQ, 0, 8'hFF, 8'hFF, 1'b0);
		queue_cmd(CMD_ENQ, 2, 8'hA5, 8'h5A, 1'b0);
		queue_cmd(CMD_ENQ, 1, 8'h5A, 8'hA5, 1'b0);
		repeat (4) queue_cmd(CMD_DEQ, 0, 8'h00, 8'h00, 1'b0);
		queue_cmd(CMD_DEQ, 3, 8'hFF, 8'hFF, 1'b0);
		// Fill one level, then overflow it.
		for (int i = 0; i < QUEUE_DEPTH; i++)
			queue_cmd(CMD_ENQ, 1, i * 17, 255 - i * 17, 1'b0);
		queue_cmd(CMD_ENQ, 1, 8'hC3, 8'h3C, 1'b0);

		first_phase = 1'b1;
		while (cmd_queue.size() < RANDOM_TOTAL) begin
			phase_len   = $urandom_range(16, 90);
			mode        = $urandom_range(0, 3);
			focus_level = $urandom_range(0, NUM_LEVELS - 1);
			case (mode)
				0: enq_pct = 85;
				1: enq_pct = 15;
				2: enq_pct = 50;
				default: enq_pct = 60;
			endcase
			for (int i = 0; i < phase_len; i++) begin
				// Fill phases pile onto one level so it overflows.
				lv = (mode == 0 && $urandom_range(0, 9) < 7) ? focus_level
					: $urandom_range(0, NUM_LEVELS - 1);
				queue_cmd(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ, lv,
					$urandom_range(0, 255), $urandom_range(0, 255),
					i == 0 && (first_phase || $urandom_range(0, 3) == 0));
				first_phase = 1'b0;
			end
		end
		total_cmds = cmd_queue.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_cmds != total_cmds) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	initial begin
		#400_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
